@@ rtl/mxed_pkg.sv @@
// Shared types and constants for the exception entry and event dispatch block.
package mxed_pkg;

  localparam int NUM_EVENTS = 11;
  localparam int SLOT_W     = 4;
  localparam int IRQ_W      = 11;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [1:0] {
    OP_ARM          = 2'd0,
    OP_BRANCH_TEST  = 2'd1,
    OP_RAISE        = 2'd2,
    OP_WRITE_STATUS = 2'd3
  } op_t;

  localparam logic [31:0] STATUS_RESET   = 32'h1090_0000;
  localparam logic [31:0] IRQ_ENABLE     = 32'h0000_0401;
  localparam logic [31:0] IRQ_CAUSE      = 32'h0000_0400;
  localparam logic [31:0] CAUSE_BD       = 32'h8000_0000;
  localparam logic [31:0] VEC_BEV        = 32'hbfc0_0180;
  localparam logic [31:0] VEC_RAM        = 32'h8000_0080;
  localparam logic [31:0] PC_STEP        = 32'd4;
  localparam logic [31:0] MODE_MASK      = 32'h0000_003f;
  localparam int          BEV_BIT        = 22;
  localparam logic [7:0]  GTE_OP_MASK    = 8'hfe;
  localparam logic [7:0]  GTE_OP_CODE    = 8'h4a;

  typedef struct packed {
    op_t               operation;
    logic [31:0]       current_cycle;
    logic [31:0]       prog_counter;
    logic [IRQ_W-1:0]  irq_status;
    logic [IRQ_W-1:0]  irq_mask;
    logic [7:0]        opcode_top;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       value;
    logic              branch_delay;
    logic [31:0]       counter_start;
    logic [31:0]       counter_delay;
  } item_t;

  typedef struct packed {
    logic [NUM_EVENTS-1:0] events_fired;
    logic                  counter_due;
    logic                  exception_taken;
    logic [31:0]           next_pc;
    logic [31:0]           exc_return_pc;
    logic [31:0]           cause_reg;
    logic [31:0]           status_reg;
  } result_t;

  // Request into the event slot table.
  typedef struct packed {
    logic              arm;
    logic              test;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       cycle;
    logic [31:0]       delay;
  } evt_req_t;

  // Request into the coprocessor register file.
  typedef struct packed {
    logic             en;
    op_t              operation;
    logic [31:0]      pc;
    logic [31:0]      value;
    logic             branch_delay;
    logic [IRQ_W-1:0] irq_status;
    logic [IRQ_W-1:0] irq_mask;
    logic [7:0]       opcode_top;
  } cop_req_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_pc;
    logic [31:0] epc;
    logic [31:0] cause;
    logic [31:0] status;
  } cop_res_t;

endpackage

@@ rtl/mxed_events.sv @@
// Timed event slot table: arm, expiry compare and pending tracking.
module mxed_events (
  input  logic                            clk,
  input  logic                            rst,
  input  mxed_pkg::evt_req_t              req,
  input  logic                            sio_suppress,
  output logic [mxed_pkg::NUM_EVENTS-1:0] fired
);
  import mxed_pkg::*;

  logic [NUM_EVENTS-1:0] pending;
  logic [31:0]           event_start [NUM_EVENTS];
  logic [31:0]           event_delay [NUM_EVENTS];
  logic                  arm_ok;

  assign arm_ok = req.arm && (req.slot < SLOT_W'(NUM_EVENTS));

  // Every slot compares in parallel against its own deadline.
  always_comb begin
    fired = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (req.test && pending[i] && !(i == 0 && sio_suppress) &&
          ((req.cycle - event_start[i]) >= event_delay[i])) begin
        fired[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (arm_ok) begin
      pending[req.slot] <= 1'b1;
    end else if (req.test) begin
      pending <= pending & ~fired;
    end
  end

  always_ff @(posedge clk) begin
    if (arm_ok) begin
      event_start[req.slot] <= req.cycle;
      event_delay[req.slot] <= req.delay;
    end
  end

  a_fired_was_pending: assert property (@(posedge clk) disable iff (rst)
    (fired & ~pending) == '0)
    else $error("slot fired while not pending");

  a_fired_cleared: assert property (@(posedge clk) disable iff (rst)
    req.test |=> (pending & $past(fired)) == '0)
    else $error("fired slot still pending");

  a_sio_held: assert property (@(posedge clk) disable iff (rst)
    sio_suppress |-> !fired[0])
    else $error("serial slot fired while suppressed");

endmodule

@@ rtl/mxed_cop0.sv @@
// Status, cause and return address registers with exception entry.
module mxed_cop0 (
  input  logic               clk,
  input  logic               rst,
  input  mxed_pkg::cop_req_t req,
  output mxed_pkg::cop_res_t res
);
  import mxed_pkg::*;

  logic [31:0] status;
  logic [31:0] cause;
  logic [31:0] epc;
  logic        hw_irq;
  logic        in_delay;
  logic [31:0] code;

  always_comb begin
    hw_irq = (req.operation == OP_BRANCH_TEST) &&
             ((req.irq_status & req.irq_mask) != '0) &&
             ((status & IRQ_ENABLE) == IRQ_ENABLE) &&
             ((req.opcode_top & GTE_OP_MASK) != GTE_OP_CODE);
    res.taken = hw_irq || (req.operation == OP_RAISE);
    in_delay  = (req.operation == OP_RAISE) && req.branch_delay;
    code      = (req.operation == OP_RAISE) ? req.value : IRQ_CAUSE;

    res.cause   = cause;
    res.epc     = epc;
    res.status  = status;
    res.next_pc = req.pc;
    if (res.taken) begin
      res.cause   = in_delay ? (code | CAUSE_BD) : code;
      res.epc     = in_delay ? (req.pc - PC_STEP) : req.pc;
      res.next_pc = status[BEV_BIT] ? VEC_BEV : VEC_RAM;
      // Push the kernel/user mode stack by one level.
      res.status  = (status & ~MODE_MASK) | ({26'd0, status[3:0], 2'b00} & MODE_MASK);
    end else if (req.operation == OP_WRITE_STATUS) begin
      res.status = req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= STATUS_RESET;
      cause  <= '0;
      epc    <= '0;
    end else if (req.en) begin
      status <= res.status;
      cause  <= res.cause;
      epc    <= res.epc;
    end
  end

  a_mode_pushed: assert property (@(posedge clk) disable iff (rst)
    req.en && res.taken |=> status[1:0] == 2'b00)
    else $error("mode stack not pushed on exception entry");

endmodule

@@ rtl/mips_exception_and_event_dispatch.sv @@
// Top level: request register, dispatch logic and result register.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that advances whenever the result
// is free or being taken. Reset clears pending slots, cause and return
// address, loads status with 0x10900000; the slot table is not cleared.
module mips_exception_and_event_dispatch (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // current_cycle, prog_counter, irq_status, irq_mask, opcode_top, slot,
  // value, branch_delay, counter_start, counter_delay, zero pad
  input  logic [mxed_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // events_fired, counter_due, exception_taken, next_pc, exc_return_pc,
  // cause_reg, status_reg, zero pad
  output logic [mxed_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mxed_pkg::*;

  logic                  sio_suppress;
  logic                  in_valid;
  item_t                 in_item;
  item_t                 s_item;
  logic                  advance;
  evt_req_t              evt_req;
  cop_req_t              cop_req;
  cop_res_t              cop_res;
  logic [NUM_EVENTS-1:0] fired;
  logic                  due;
  result_t               res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sio_suppress <= 1'b0;
    end else if (cfg_valid) begin
      sio_suppress <= cfg_data;
    end
  end

  always_comb begin
    s_item.operation     = op_t'(s_axis_tuser);
    s_item.current_cycle = s_axis_tdata[31:0];
    s_item.prog_counter  = s_axis_tdata[63:32];
    s_item.irq_status    = s_axis_tdata[74:64];
    s_item.irq_mask      = s_axis_tdata[85:75];
    s_item.opcode_top    = s_axis_tdata[93:86];
    s_item.slot          = s_axis_tdata[97:94];
    s_item.value         = s_axis_tdata[129:98];
    s_item.branch_delay  = s_axis_tdata[130];
    s_item.counter_start = s_axis_tdata[162:131];
    s_item.counter_delay = s_axis_tdata[194:163];
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_item;
    end
  end

  always_comb begin
    evt_req.arm   = advance && (in_item.operation == OP_ARM);
    evt_req.test  = advance && (in_item.operation == OP_BRANCH_TEST);
    evt_req.slot  = in_item.slot;
    evt_req.cycle = in_item.current_cycle;
    evt_req.delay = in_item.value;

    cop_req.en           = advance;
    cop_req.operation    = in_item.operation;
    cop_req.pc           = in_item.prog_counter;
    cop_req.value        = in_item.value;
    cop_req.branch_delay = in_item.branch_delay;
    cop_req.irq_status   = in_item.irq_status;
    cop_req.irq_mask     = in_item.irq_mask;
    cop_req.opcode_top   = in_item.opcode_top;
  end

  mxed_events u_events (
    .clk          (clk),
    .rst          (rst),
    .req          (evt_req),
    .sio_suppress (sio_suppress),
    .fired        (fired)
  );

  mxed_cop0 u_cop0 (
    .clk (clk),
    .rst (rst),
    .req (cop_req),
    .res (cop_res)
  );

  assign due = (in_item.operation == OP_BRANCH_TEST) &&
               ((in_item.current_cycle - in_item.counter_start) >= in_item.counter_delay);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.events_fired    <= fired;
      res.counter_due     <= due;
      res.exception_taken <= cop_res.taken;
      res.next_pc         <= cop_res.next_pc;
      res.exc_return_pc   <= cop_res.epc;
      res.cause_reg       <= cop_res.cause;
      res.status_reg      <= cop_res.status;
    end
  end

  assign m_axis_tdata = {3'b000, res.status_reg, res.cause_reg, res.exc_return_pc,
                         res.next_pc, res.exception_taken, res.counter_due,
                         res.events_fired};

  a_vector: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.exception_taken |->
      (res.next_pc == VEC_BEV) || (res.next_pc == VEC_RAM))
    else $error("exception taken with bad vector");

  a_no_test_no_fire: assert property (@(posedge clk) disable iff (rst)
    advance && (in_item.operation != OP_BRANCH_TEST) |=> res.events_fired == '0 &&
      !res.counter_due)
    else $error("event activity outside branch test");

endmodule
